[hdl/cst_pkg.sv]
// Types and codes shared by the semaphore table blocks.
package cst_pkg;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_SIGNAL = 2'd2,
    KIND_FREE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  owner_id;
    logic [63:0] name_key;
    logic [14:0] initial_value;
    logic [7:0]  waiter_slot;
    logic [5:0]  sem_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_out;
    logic       caller_blocked;
    logic       woken_valid;
    logic [7:0] woken_slot;
  } rsp_t;

  localparam logic signed [15:0] COUNT_MAX = 16'sd32767;
  localparam logic signed [15:0] COUNT_MIN = -16'sd32768;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SCAN_WAIT,
    BK_EXEC,
    BK_RD_NEXT,
    BK_RD_WAIT,
    BK_DONE
  } bk_state_t;

endpackage

[hdl/cst_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[hdl/cst_front.sv]
// Request intake: masks the name key to KEY_BITS and queues the requests for the back end.
module cst_front #(
  parameter int KEY_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  cst_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_take,
  output cst_pkg::req_t q_req
);
  import cst_pkg::*;

  // Two-entry request queue.
  req_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  req_t       clean;
  logic       do_push, do_pop;

  always_comb begin
    clean = in_req;
    clean.name_key = in_req.name_key & ({64{1'b1}} >> (64 - KEY_BITS));
  end

  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign do_pop  = q_take && q_valid;
  assign q_req   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= clean;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("request queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |=> cnt_r != 2'd3)
    else $error("request queue underflow");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("request queue pointers out of step");
`endif
endmodule

[hdl/cst_back.sv]
// Execution engine: table scan, count update, wait-queue links, result register.
module cst_back #(
  parameter int SEM_COUNT    = 64,
  parameter int WAITER_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_take,
  input  cst_pkg::req_t q_req,
  output logic          out_empty,
  input  logic          out_pop,
  output cst_pkg::rsp_t out_rsp
);
  import cst_pkg::*;

  localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int WW = (WAITER_COUNT > 1) ? $clog2(WAITER_COUNT) : 1;
  localparam int CW = $clog2(SEM_COUNT + 1);
  localparam int ENT_W = 10 + 64 + 16 + 2 * WW;
  // waiter slot modulo WAITER_COUNT by reciprocal multiply, exact for 8-bit slots
  localparam int RK = 17;
  localparam int RM = ((2 ** RK) + WAITER_COUNT - 1) / WAITER_COUNT;

  typedef struct packed {
    logic [9:0]         owner;
    logic [63:0]        key;
    logic signed [15:0] count;
    logic [WW-1:0]      head;
    logic [WW-1:0]      tail;
  } ent_t;

  bk_state_t     st_r, st_nxt;
  req_t          req_r;
  logic [SEM_COUNT-1:0] valid_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] hit_idx_r, hit_idx_nxt;
  logic          fre_r, fre_nxt;
  logic [SW-1:0] fre_idx_r, fre_idx_nxt;
  ent_t          ent_r;
  rsp_t          pend_r, pend_nxt;
  rsp_t          res_r, res_nxt;
  logic          res_v_r, res_v_nxt;

  logic          e_we;
  logic [SW-1:0] e_wa, e_ra;
  ent_t          e_wd, e_rd;
  logic          n_we;
  logic [WW-1:0] n_wa, n_wd, n_ra, n_rd;
  logic          set_v, clr_v;
  logic [SW-1:0] v_idx;
  logic [WW-1:0] waiter;
  logic [24:0]   w_prod;
  logic [7:0]    w_quo;
  logic [7:0]    w_rem;
  logic signed [15:0] cnt_m1, cnt_p1;
  logic [SW-1:0] scan_ix;

  cst_ram #(.WIDTH(ENT_W), .DEPTH(SEM_COUNT)) u_ent (
    .clk(clk), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
    .rd_addr(e_ra), .rd_data(e_rd));

  cst_ram #(.WIDTH(WW), .DEPTH(WAITER_COUNT)) u_next (
    .clk(clk), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
    .rd_addr(n_ra), .rd_data(n_rd));

  assign w_prod    = 25'(req_r.waiter_slot) * 25'(RM);
  assign w_quo     = w_prod[24:17];
  assign w_rem     = req_r.waiter_slot - 8'(32'(w_quo) * WAITER_COUNT);
  assign waiter    = WW'(w_rem);
  assign out_empty = !res_v_r;
  assign out_rsp   = res_r;
  assign cnt_m1    = ent_r.count - 16'sd1;
  assign cnt_p1    = ent_r.count + 16'sd1;
  assign scan_ix   = idx_r[SW-1:0];

  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    fre_nxt     = fre_r;
    fre_idx_nxt = fre_idx_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    res_v_nxt   = res_v_r && !out_pop;
    q_take      = 1'b0;
    e_we = 1'b0; e_wa = hit_idx_r; e_wd = ent_r; e_ra = scan_ix;
    n_we = 1'b0; n_wa = ent_r.tail; n_wd = waiter;
    n_ra = ent_r.head;
    set_v = 1'b0; clr_v = 1'b0; v_idx = hit_idx_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          fre_nxt = 1'b0;
          st_nxt = (q_req.kind == KIND_FREE) ? BK_EXEC : BK_SCAN;
        end
      end
      BK_SCAN: begin
        // one entry per cycle; read issued here, compared next cycle
        e_ra = scan_ix;
        st_nxt = BK_SCAN_WAIT;
      end
      BK_SCAN_WAIT: begin
        if (valid_r[scan_ix] && e_rd.owner == req_r.owner_id
            && e_rd.key == req_r.name_key && !hit_r) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = scan_ix;
        end
        if (!valid_r[scan_ix] && !fre_r) begin
          fre_nxt = 1'b1;
          fre_idx_nxt = scan_ix;
        end
        if (idx_r == CW'(SEM_COUNT - 1)) begin
          st_nxt = BK_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
          e_ra = SW'(idx_r + 1'b1);
          st_nxt = BK_SCAN_WAIT;
        end
      end
      BK_EXEC: begin
        pend_nxt = '0;
        st_nxt = BK_DONE;
        case (req_r.kind)
          KIND_CREATE: begin
            if (hit_r) begin
              pend_nxt.status = ST_EXISTS;
              pend_nxt.slot_out = 6'(hit_idx_r);
            end else if (!fre_r) begin
              pend_nxt.status = ST_FULL;
            end else begin
              e_we = 1'b1; e_wa = fre_idx_r;
              e_wd.owner = req_r.owner_id;
              e_wd.key = req_r.name_key;
              e_wd.count = {1'b0, req_r.initial_value};
              set_v = 1'b1; v_idx = fre_idx_r;
              pend_nxt.slot_out = 6'(fre_idx_r);
            end
          end
          KIND_WAIT: begin
            if (!hit_r) begin
              pend_nxt.status = ST_NOT_FOUND;
            end else begin
              pend_nxt.slot_out = 6'(hit_idx_r);
              if (ent_r.count == COUNT_MIN) begin
                pend_nxt.status = ST_SATURATED;
              end else begin
                e_we = 1'b1;
                e_wd.count = cnt_m1;
                if (cnt_m1 < 0) begin
                  if (cnt_m1 == -16'sd1) begin
                    e_wd.head = waiter;
                  end else begin
                    n_we = 1'b1;
                  end
                  e_wd.tail = waiter;
                  pend_nxt.caller_blocked = 1'b1;
                end
              end
            end
          end
          KIND_SIGNAL: begin
            if (!hit_r) begin
              pend_nxt.status = ST_NOT_FOUND;
            end else begin
              pend_nxt.slot_out = 6'(hit_idx_r);
              if (ent_r.count == COUNT_MAX) begin
                pend_nxt.status = ST_SATURATED;
              end else begin
                e_we = 1'b1;
                e_wd.count = cnt_p1;
                if (cnt_p1 <= 0) begin
                  pend_nxt.woken_valid = 1'b1;
                  pend_nxt.woken_slot = 8'(ent_r.head);
                  if (cnt_p1 < 0) begin
                    st_nxt = BK_RD_NEXT;
                  end
                end
              end
            end
          end
          default: begin
            if (32'(req_r.sem_index) >= SEM_COUNT) begin
              pend_nxt.status = ST_NOT_FOUND;
            end else begin
              clr_v = 1'b1;
              v_idx = SW'(req_r.sem_index);
            end
          end
        endcase
      end
      BK_RD_NEXT: begin
        n_ra = ent_r.head;
        st_nxt = BK_RD_WAIT;
      end
      BK_RD_WAIT: begin
        e_we = 1'b1;
        e_wd.count = ent_r.count;
        e_wd.head = n_rd;
        st_nxt = BK_DONE;
      end
      BK_DONE: begin
        // hand over only once the previous beat has left the result register
        if (!res_v_r || out_pop) begin
          res_nxt = pend_r;
          res_v_nxt = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      valid_r <= '0;
      res_v_r <= 1'b0;
      hit_r   <= 1'b0;
      fre_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      res_v_r <= res_v_nxt;
      hit_r   <= hit_nxt;
      fre_r   <= fre_nxt;
      idx_r   <= idx_nxt;
      if (set_v) valid_r[v_idx] <= 1'b1;
      if (clr_v) valid_r[v_idx] <= 1'b0;
    end
    hit_idx_r <= hit_idx_nxt;
    fre_idx_r <= fre_idx_nxt;
    pend_r    <= pend_nxt;
    res_r     <= res_nxt;
    if (q_take) req_r <= q_req;
    if (st_r == BK_SCAN_WAIT && !hit_r && hit_nxt) ent_r <= e_rd;
    if (st_r == BK_EXEC && e_we) ent_r <= e_wd;
  end

`ifndef NO_ASSERTIONS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == BK_IDLE)
    else $error("request taken while busy");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_DONE && st_nxt == BK_IDLE |=> res_v_r)
    else $error("result not posted");
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_EXEC && hit_r && req_r.kind != KIND_FREE |-> valid_r[hit_idx_r])
    else $error("matched slot not valid");
`endif
endmodule

[hdl/counting_semaphore_table_core.sv]
// A free skips the table scan; create, wait and signal scan every table entry,
// and a signal that also relinks its queue reads the next-link RAM after the update.
// The table scan reads one entry of the entry RAM per cycle and sets the rate.
// A second request can wait in the two-beat intake queue while one executes.
// Reset (rst_n low, synchronous) clears all slot valid bits, the intake queue and the result register.
module counting_semaphore_table_core #(
  parameter int SEM_COUNT    = 64,
  parameter int WAITER_COUNT = 256,
  parameter int KEY_BITS     = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  cst_pkg::req_t in_req,
  output logic          out_empty,
  input  logic          out_pop,
  output cst_pkg::rsp_t out_rsp
);
  import cst_pkg::*;

  logic q_valid, q_take;
  req_t q_req;

  // front: accepts beats, masks the key to KEY_BITS
  cst_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req));

  // back: scan, update, link maintenance and result register
  cst_back #(.SEM_COUNT(SEM_COUNT), .WAITER_COUNT(WAITER_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_req(q_req), .out_empty(out_empty), .out_pop(out_pop),
    .out_rsp(out_rsp));
endmodule
